FILE: rtl/core/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg
// Shared types and constants for the two-heap running median core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmth_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MEDIAN_W = 33;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic {
    HEAP_LOWER,  // max-heap
    HEAP_UPPER   // min-heap
  } heap_e;

  typedef enum logic [1:0] {
    VAL_SAMPLE,
    VAL_LO_TOP,
    VAL_UP_TOP
  } val_sel_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PUSH_INIT,
    OP_UP_READ,
    OP_UP_MOVE,
    OP_UP_FINAL,
    OP_DN_INIT,
    OP_DN_READ,
    OP_DN_MOVE,
    OP_DN_FINAL,
    OP_RESULT
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_START,
    S_DN_CHK,
    S_DN_CMP,
    S_RESULT,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e      op;
    heap_e    heap;
    val_sel_e vsel;
    logic     rejected;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic upper_empty;
    logic sizes_equal;
    logic below_lo_top;
    logic above_up_top;
    logic at_root;
    logic up_move;
    logic dn_leaf;
    logic dn_move;
  } dp_status_t;

  // true when a belongs above b
  function automatic logic heap_before(input logic is_max,
                                       input logic signed [SAMPLE_W-1:0] a,
                                       input logic signed [SAMPLE_W-1:0] b);
    return is_max ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rmth_datapath.sv
// ----------------------------------------------------------------------------
// rmth_datapath
// Heap memories, sizes, top-of-heap copies and the sift compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rmth_datapath
  import rmth_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  dp_cmd_t                       cmd_i,
  output dp_status_t                    status_o,
  input  wire  logic signed [SAMPLE_W-1:0] sample_i,
  output logic signed [MEDIAN_W-1:0]    median_doubled_o,
  output logic [COUNT_W-1:0]            stored_count_o,
  output logic                          rejected_o
);

  localparam int unsigned LD  = CAPACITY / 2;
  localparam int unsigned UD  = CAPACITY - CAPACITY / 2;
  localparam int unsigned LAW = (LD > 1) ? $clog2(LD) : 1;
  localparam int unsigned UAW = (UD > 1) ? $clog2(UD) : 1;
  localparam int unsigned IW  = $clog2(UD + 1);
  localparam int unsigned TW  = $clog2(CAPACITY + 1);

  logic signed [SAMPLE_W-1:0] lo_mem [LD];
  logic signed [SAMPLE_W-1:0] up_mem [UD];

  logic signed [SAMPLE_W-1:0] sample_q, v_q, lo_top_q, up_top_q;
  logic signed [SAMPLE_W-1:0] lo_a_q, lo_b_q, up_a_q, up_b_q;
  heap_e                      h_q;
  logic [IW-1:0]              idx_q, lo_size_q, up_size_q;

  logic                       is_max, has2, pick_b, rd_en, we;
  logic [IW-1:0]              cur_size, idx_m1, parent;
  logic [IW:0]                child_a, child_b, child_idx, rd_addr_a;
  logic signed [SAMPLE_W-1:0] rd_a, rd_b, child_val, wd, push_val;
  logic [TW-1:0]              total;

  assign is_max    = (h_q == HEAP_LOWER);
  assign cur_size  = is_max ? lo_size_q : up_size_q;
  assign idx_m1    = idx_q - IW'(1);
  assign parent    = idx_m1 >> 1;
  assign child_a   = {idx_q, 1'b1};
  assign child_b   = child_a + (IW+1)'(1);
  assign rd_a      = is_max ? lo_a_q : up_a_q;
  assign rd_b      = is_max ? lo_b_q : up_b_q;
  assign has2      = child_b < {1'b0, cur_size};
  assign pick_b    = has2 && heap_before(is_max, rd_b, rd_a);
  assign child_val = pick_b ? rd_b : rd_a;
  assign child_idx = pick_b ? child_b : child_a;
  assign total     = TW'({1'b0, lo_size_q} + {1'b0, up_size_q});

  assign rd_en     = (cmd_i.op == OP_UP_READ) || (cmd_i.op == OP_DN_READ);
  assign rd_addr_a = (cmd_i.op == OP_UP_READ) ? {1'b0, parent} : child_a;

  always_comb begin
    we = 1'b1;
    unique case (cmd_i.op)
      OP_UP_MOVE:  wd = rd_a;
      OP_DN_MOVE:  wd = child_val;
      OP_UP_FINAL,
      OP_DN_FINAL: wd = v_q;
      default: begin
        we = 1'b0;
        wd = v_q;
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.vsel)
      VAL_LO_TOP: push_val = lo_top_q;
      VAL_UP_TOP: push_val = up_top_q;
      default:    push_val = sample_q;
    endcase
  end

  always_comb begin
    status_o.full         = total >= TW'(CAPACITY);
    status_o.upper_empty  = (up_size_q == '0);
    status_o.sizes_equal  = (up_size_q == lo_size_q);
    status_o.below_lo_top = sample_q < lo_top_q;
    status_o.above_up_top = sample_q > up_top_q;
    status_o.at_root      = (idx_q == '0);
    status_o.up_move      = heap_before(is_max, v_q, rd_a);
    status_o.dn_leaf      = child_a >= {1'b0, cur_size};
    status_o.dn_move      = heap_before(is_max, child_val, v_q);
  end

  // lower heap memory
  always_ff @(posedge clk_i) begin
    if (we && is_max) lo_mem[idx_q[LAW-1:0]] <= wd;
    if (rd_en) begin
      lo_a_q <= lo_mem[rd_addr_a[LAW-1:0]];
      lo_b_q <= lo_mem[child_b[LAW-1:0]];
    end
  end

  // upper heap memory
  always_ff @(posedge clk_i) begin
    if (we && !is_max) up_mem[idx_q[UAW-1:0]] <= wd;
    if (rd_en) begin
      up_a_q <= up_mem[rd_addr_a[UAW-1:0]];
      up_b_q <= up_mem[child_b[UAW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_size_q <= '0;
      up_size_q <= '0;
    end else if (cmd_i.op == OP_PUSH_INIT) begin
      if (cmd_i.heap == HEAP_LOWER) lo_size_q <= lo_size_q + IW'(1);
      else                          up_size_q <= up_size_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we && is_max && idx_q == '0)  lo_top_q <= wd;
    if (we && !is_max && idx_q == '0) up_top_q <= wd;
    case (cmd_i.op)
      OP_LOAD: sample_q <= sample_i;
      OP_PUSH_INIT: begin
        h_q   <= cmd_i.heap;
        v_q   <= push_val;
        idx_q <= (cmd_i.heap == HEAP_LOWER) ? lo_size_q : up_size_q;
      end
      OP_DN_INIT: begin
        h_q   <= cmd_i.heap;
        v_q   <= sample_q;
        idx_q <= '0;
      end
      OP_UP_MOVE: idx_q <= parent;
      OP_DN_MOVE: idx_q <= child_idx[IW-1:0];
      OP_RESULT: begin
        median_doubled_o <= status_o.sizes_equal
                            ? ({lo_top_q[SAMPLE_W-1], lo_top_q}
                               + {up_top_q[SAMPLE_W-1], up_top_q})
                            : {up_top_q, 1'b0};
        stored_count_o   <= COUNT_W'(total);
        rejected_o       <= cmd_i.rejected;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/rmth_ctrl.sv
// ----------------------------------------------------------------------------
// rmth_ctrl
// Sequencer: picks the insert case, walks sift-up and sift-down, hands out.
// ----------------------------------------------------------------------------
`default_nettype none

module rmth_ctrl
  import rmth_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   pend_q, pend_d, rej_q, rej_d;
  heap_e  repl_q, repl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      rej_q   <= 1'b0;
      repl_q  <= HEAP_LOWER;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      rej_q   <= rej_d;
      repl_q  <= repl_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pend_d        = pend_q;
    rej_d         = rej_q;
    repl_d        = repl_q;
    cmd_o.op      = OP_NONE;
    cmd_o.heap    = HEAP_UPPER;
    cmd_o.vsel    = VAL_SAMPLE;
    cmd_o.rejected = rej_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          rej_d    = 1'b0;
          pend_d   = 1'b0;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.full) begin
          rej_d   = 1'b1;
          state_d = S_RESULT;
        end else begin
          cmd_o.op = OP_PUSH_INIT;
          state_d  = S_UP_CHK;
          if (status_i.upper_empty) begin
            cmd_o.heap = HEAP_UPPER;
          end else if (status_i.sizes_equal) begin
            cmd_o.heap = HEAP_UPPER;
            if (status_i.below_lo_top) begin
              cmd_o.vsel = VAL_LO_TOP;
              pend_d     = 1'b1;
              repl_d     = HEAP_LOWER;
            end
          end else begin
            cmd_o.heap = HEAP_LOWER;
            if (status_i.above_up_top) begin
              cmd_o.vsel = VAL_UP_TOP;
              pend_d     = 1'b1;
              repl_d     = HEAP_UPPER;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (status_i.at_root) begin
          cmd_o.op = OP_UP_FINAL;
          state_d  = pend_q ? S_DN_START : S_RESULT;
        end else begin
          cmd_o.op = OP_UP_READ;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status_i.up_move) begin
          cmd_o.op = OP_UP_MOVE;
          state_d  = S_UP_CHK;
        end else begin
          cmd_o.op = OP_UP_FINAL;
          state_d  = pend_q ? S_DN_START : S_RESULT;
        end
      end
      S_DN_START: begin
        cmd_o.op   = OP_DN_INIT;
        cmd_o.heap = repl_q;
        pend_d     = 1'b0;
        state_d    = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (status_i.dn_leaf) begin
          cmd_o.op = OP_DN_FINAL;
          state_d  = S_RESULT;
        end else begin
          cmd_o.op = OP_DN_READ;
          state_d  = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (status_i.dn_move) begin
          cmd_o.op = OP_DN_MOVE;
          state_d  = S_DN_CHK;
        end else begin
          cmd_o.op = OP_DN_FINAL;
          state_d  = S_RESULT;
        end
      end
      S_RESULT: begin
        cmd_o.op = OP_RESULT;
        state_d  = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/running_median_two_heaps_core.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_core
// Streaming running median over signed 32-bit samples using two heaps.
// ----------------------------------------------------------------------------
// Each accepted sample request is inserted into a max-heap (lower half) and
// a min-heap (upper half, one extra on odd counts), and one result comes
// back: twice the current median as an exact 33-bit value, the stored count
// and a reject flag. Once CAPACITY samples are held, further samples are
// dropped, state is kept, and rejected is set. One request is in flight at
// a time: in_ready_o is high only while idle. A reject passes through the
// accept, decide, result and output states; a push also sifts up, each
// step reading the parent, then comparing and writing. When a top moves to
// the other heap the replaced root is then sifted down: a setup step, then
// a read and a compare/move per level, ending at a leaf or where the
// compare stops it. At CAPACITY 1024 (heaps of 512) the worst case walks
// nine levels up to the root and nine levels down, and the output side can
// add any stall on top of that.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_two_heaps_core
  import rmth_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic signed [MEDIAN_W-1:0]     median_doubled_o,
  output logic [COUNT_W-1:0]             stored_count_o,
  output logic                           rejected_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: insert-case decision and sift walk
  rmth_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // heaps, sizes and result register
  rmth_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_i         (sample_i),
    .median_doubled_o (median_doubled_o),
    .stored_count_o   (stored_count_o),
    .rejected_o       (rejected_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rmth_checker.sv
// ----------------------------------------------------------------------------
// rmth_checker
// Port-level checks for the running median core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmth_checker
  import rmth_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       in_valid_i,
  input wire                       in_ready_o,
  input wire                       out_valid_o,
  input wire                       out_ready_i,
  input wire [MEDIAN_W-1:0]        median_doubled_o,
  input wire [COUNT_W-1:0]         stored_count_o,
  input wire                       rejected_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_doubled_o))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // no input taken while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");

  // reject only at full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> stored_count_o == COUNT_W'(CAPACITY))
    else $error("reject below capacity");

  // an accepted result never shows an empty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !rejected_o |-> stored_count_o != '0 || CAPACITY >= 2048)
    else $error("empty count on accept");

endmodule

bind running_median_two_heaps_core rmth_checker #(
  .CAPACITY (CAPACITY)
) u_rmth_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .median_doubled_o (median_doubled_o),
  .stored_count_o   (stored_count_o),
  .rejected_o       (rejected_o)
);

`default_nettype wire
